>>> rtl/cfrp_pkg.sv
`timescale 1ns / 1ps

package cfrp_pkg;

  // Register file size; register numbers are REG_W bits wide.
  localparam int NUM_REGS = 32;
  localparam int REG_W    = 5;
  localparam int MASK_W   = 32;
  localparam int CNT_W    = $clog2(NUM_REGS);
  localparam int CFG_IDX_W = 3;

  // Request codes
  localparam logic [1:0] REQ_RESTART = 2'd0;
  localparam logic [1:0] REQ_FIXED   = 2'd1;
  localparam logic [1:0] REQ_FLOAT   = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_ALLOC   = 2'd0;
  localparam logic [1:0] STAT_NONE    = 2'd1;
  localparam logic [1:0] STAT_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_LAST    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_RESTART = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_FIRST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_LAST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_RESTART = 3'd5;

  // Configuration reset values
  localparam logic [REG_W-1:0] RST_FIXED_FIRST   = 5'd11;
  localparam logic [REG_W-1:0] RST_FIXED_LAST    = 5'd31;
  localparam logic [REG_W-1:0] RST_FIXED_RESTART = 5'd11;
  localparam logic [REG_W-1:0] RST_FLOAT_FIRST   = 5'd1;
  localparam logic [REG_W-1:0] RST_FLOAT_LAST    = 5'd13;
  localparam logic [REG_W-1:0] RST_FLOAT_RESTART = 5'd1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [MASK_W-1:0] busy_mask;
  } in_word_t;

  typedef struct packed {
    logic [REG_W-1:0] reg_num;
    logic [1:0]       status;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Launch of one scan
  typedef struct packed {
    logic              start;
    logic [REG_W-1:0]  ptr;
    logic [REG_W-1:0]  first;
    logic [REG_W-1:0]  last;
    logic [MASK_W-1:0] mask;
  } scan_cmd_t;

  // Scan outcome, valid while done is high
  typedef struct packed {
    logic             done;
    logic             found;
    logic [REG_W-1:0] reg_num;
    logic [REG_W-1:0] ptr_nxt;
  } scan_sts_t;

endpackage

>>> rtl/cyclic_free_register_picker.sv
`timescale 1ns / 1ps

// Channel  Handshake            Word
// in       in_valid / in_stall   in_data   (req_type, busy_mask)
// out      out_valid / out_stall out_data  (reg_num, status)
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A get request scans one register per cycle in the shared scan unit, at most
// 32 registers, and then hands the word to the output register.
// Restart and unknown requests skip the scan and go straight to the hand-off.
// in_stall is high from acceptance until the result moves to the output register;
// a new word is then taken while the result still waits on out_stall.
// Reset loads the configuration reset values and both pointers from them.
module cyclic_free_register_picker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cfrp_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cfrp_pkg::out_word_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfrp_pkg::REG_W-1:0]     cfg_data
);

  cfrp_pkg::state_t            state_r, state_nxt;
  logic [cfrp_pkg::REG_W-1:0]  fixed_first_r, fixed_last_r, fixed_restart_r;
  logic [cfrp_pkg::REG_W-1:0]  float_first_r, float_last_r, float_restart_r;
  logic [cfrp_pkg::REG_W-1:0]  fixed_next_r, float_next_r;
  logic                        pool_float_r;
  cfrp_pkg::out_word_t         res_r, res_nxt;
  cfrp_pkg::out_word_t         out_data_r;
  logic                        out_valid_r;
  logic                        in_acc;
  logic                        is_get;
  logic                        slot_free;
  logic                        out_load;
  cfrp_pkg::scan_cmd_t         cmd;
  cfrp_pkg::scan_sts_t         sts;

  cfrp_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign is_get    = (in_data.req_type == cfrp_pkg::REQ_FIXED) ||
                     (in_data.req_type == cfrp_pkg::REQ_FLOAT);
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfrp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = is_get ? cfrp_pkg::ST_SCAN : cfrp_pkg::ST_DONE;
        end
      end
      cfrp_pkg::ST_SCAN: begin
        if (sts.done) begin
          state_nxt = cfrp_pkg::ST_DONE;
        end
      end
      cfrp_pkg::ST_DONE: begin
        if (slot_free) begin
          state_nxt = cfrp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cfrp_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state_r)
      cfrp_pkg::ST_IDLE: in_stall = 1'b0;
      cfrp_pkg::ST_SCAN: in_stall = 1'b1;
      cfrp_pkg::ST_DONE: out_load = slot_free;
      default:           in_stall = 1'b1;
    endcase
  end

  always_comb begin
    cmd.start = in_acc && is_get;
    cmd.mask  = in_data.busy_mask;
    if (in_data.req_type == cfrp_pkg::REQ_FLOAT) begin
      cmd.ptr   = float_next_r;
      cmd.first = float_first_r;
      cmd.last  = float_last_r;
    end else begin
      cmd.ptr   = fixed_next_r;
      cmd.first = fixed_first_r;
      cmd.last  = fixed_last_r;
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (in_acc) begin
      res_nxt.reg_num = '0;
      res_nxt.status  = (in_data.req_type == cfrp_pkg::REQ_RESTART) ?
                        cfrp_pkg::STAT_RESTART : cfrp_pkg::STAT_NONE;
    end else if (sts.done) begin
      res_nxt.reg_num = sts.found ? sts.reg_num : '0;
      res_nxt.status  = sts.found ? cfrp_pkg::STAT_ALLOC : cfrp_pkg::STAT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= cfrp_pkg::ST_IDLE;
      out_valid_r     <= 1'b0;
      fixed_first_r   <= cfrp_pkg::RST_FIXED_FIRST;
      fixed_last_r    <= cfrp_pkg::RST_FIXED_LAST;
      fixed_restart_r <= cfrp_pkg::RST_FIXED_RESTART;
      float_first_r   <= cfrp_pkg::RST_FLOAT_FIRST;
      float_last_r    <= cfrp_pkg::RST_FLOAT_LAST;
      float_restart_r <= cfrp_pkg::RST_FLOAT_RESTART;
      fixed_next_r    <= cfrp_pkg::RST_FIXED_RESTART;
      float_next_r    <= cfrp_pkg::RST_FLOAT_RESTART;
    end else begin
      state_r <= state_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          cfrp_pkg::CFG_FIXED_FIRST:   fixed_first_r   <= cfg_data;
          cfrp_pkg::CFG_FIXED_LAST:    fixed_last_r    <= cfg_data;
          cfrp_pkg::CFG_FIXED_RESTART: fixed_restart_r <= cfg_data;
          cfrp_pkg::CFG_FLOAT_FIRST:   float_first_r   <= cfg_data;
          cfrp_pkg::CFG_FLOAT_LAST:    float_last_r    <= cfg_data;
          cfrp_pkg::CFG_FLOAT_RESTART: float_restart_r <= cfg_data;
          default: ;
        endcase
      end

      // Restart loads both pointers; a hit leaves the pool pointer past it.
      if (in_acc && in_data.req_type == cfrp_pkg::REQ_RESTART) begin
        fixed_next_r <= fixed_restart_r;
        float_next_r <= float_restart_r;
      end else if (sts.done && sts.found) begin
        if (pool_float_r) begin
          float_next_r <= sts.ptr_nxt;
        end else begin
          fixed_next_r <= sts.ptr_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_acc) begin
      pool_float_r <= (in_data.req_type == cfrp_pkg::REQ_FLOAT);
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

endmodule

>>> rtl/cfrp_scan.sv
`timescale 1ns / 1ps

module cfrp_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  cfrp_pkg::scan_cmd_t cmd,
  output cfrp_pkg::scan_sts_t sts
);

  logic                           busy_r, busy_nxt;
  logic [cfrp_pkg::REG_W-1:0]     p_r, p_nxt;
  logic [cfrp_pkg::REG_W-1:0]     start_r;
  logic [cfrp_pkg::REG_W-1:0]     first_r;
  logic [cfrp_pkg::REG_W-1:0]     last_r;
  logic [cfrp_pkg::MASK_W-1:0]    mask_r;
  logic [cfrp_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [cfrp_pkg::REG_W-1:0]     step;
  logic                           is_free;
  logic                           give_up;

  // Step the pointer: wrap to first after last, else modulo the register count.
  assign step    = (p_r == last_r) ? first_r : p_r + cfrp_pkg::REG_W'(1);
  assign is_free = ~mask_r[p_r];
  assign give_up = (step == start_r) ||
                   (cnt_r == cfrp_pkg::CNT_W'(cfrp_pkg::NUM_REGS - 1));

  always_comb begin
    sts.done    = busy_r && (is_free || give_up);
    sts.found   = is_free;
    sts.reg_num = p_r;
    sts.ptr_nxt = step;
  end

  always_comb begin
    busy_nxt = busy_r;
    p_nxt    = p_r;
    cnt_nxt  = cnt_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      p_nxt    = cmd.ptr;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (sts.done) begin
        busy_nxt = 1'b0;
      end else begin
        p_nxt   = step;
        cnt_nxt = cnt_r + cfrp_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    cnt_r <= cnt_nxt;
    if (cmd.start) begin
      start_r <= cmd.ptr;
      first_r <= cmd.first;
      last_r  <= cmd.last;
      mask_r  <= cmd.mask;
    end
  end

endmodule
